// ===== hdl/nmea_time_date_rollover_unit_defines.svh =====
// ----------------------------------------------------------------------------
// nmea_time_date_rollover_unit_defines.svh
// assertion macros shared by the time/date rollover rtl
// ----------------------------------------------------------------------------
`ifndef NMEA_TIME_DATE_ROLLOVER_UNIT_DEFINES_SVH
`define NMEA_TIME_DATE_ROLLOVER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define NMTD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NMTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/nmtd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmtd_pkg
// payload types and constant-divisor helpers for the time/date rollover unit
// ----------------------------------------------------------------------------
package nmtd_pkg;

	typedef struct packed {
		logic [24:0] time_code;
		logic [18:0] date_code;
		logic [31:0] log_tick;
		logic [31:0] now_tick;
	} fix_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millis;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       day_advanced;
	} utc_t;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} date_t;

	// decoded fields handed from the decode stages to the carry stages
	typedef struct packed {
		logic [10:0] ms;
		logic [22:0] eq;
		logic [6:0]  ss;
		logic [6:0]  mm;
		logic [5:0]  hh;
		date_t       date_keep;
		date_t       date_next;
	} dec_t;

	// reciprocals, exact for any 32-bit dividend
	localparam logic [31:0] Recip100  = 32'h51EB851F;
	localparam int unsigned Shift100  = 37;
	localparam logic [31:0] Recip1000 = 32'h10624DD3;
	localparam int unsigned Shift1000 = 38;
	localparam logic [31:0] Recip60   = 32'h88888889;
	localparam int unsigned Shift60   = 37;
	localparam logic [31:0] Recip24   = 32'hAAAAAAAB;
	localparam int unsigned Shift24   = 36;

	function automatic logic [31:0] div100(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'(Recip100);
		return 32'(p >> Shift100);
	endfunction

	function automatic logic [31:0] div1000(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'(Recip1000);
		return 32'(p >> Shift1000);
	endfunction

	function automatic logic [31:0] div60(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'(Recip60);
		return 32'(p >> Shift60);
	endfunction

	function automatic logic [31:0] div24(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'(Recip24);
		return 32'(p >> Shift24);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/nmtd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmtd_decode
// stages 1-4: tick difference and scaling, decimal digit split of the time
// and date codes, millisecond sum and the next-day date
// ----------------------------------------------------------------------------
`include "nmea_time_date_rollover_unit_defines.svh"

module nmtd_decode #(
	parameter int unsigned TICK_MS = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            fix_valid,
	input  nmtd_pkg::fix_t  fix,
	output logic            dec_valid,
	output nmtd_pkg::dec_t  dec
);

	localparam logic [6:0] MonFeb = 7'd2;
	localparam logic [6:0] MonApr = 7'd4;
	localparam logic [6:0] MonJun = 7'd6;
	localparam logic [6:0] MonSep = 7'd9;
	localparam logic [6:0] MonNov = 7'd11;
	localparam logic [6:0] MonDec = 7'd12;

	function automatic logic [4:0] month_len(input logic [6:0] mo, input logic [6:0] yy);
		logic [4:0] len;
		if (mo == MonApr || mo == MonJun || mo == MonSep || mo == MonNov) begin
			len = 5'd30;
		end else if (mo == MonFeb) begin
			len = (yy[1:0] == 2'd0) ? 5'd29 : 5'd28;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	// date one day later; a month outside 1..12 only bumps the day
	function automatic nmtd_pkg::date_t next_date(input logic [5:0] dd, input logic [6:0] mo,
			input logic [6:0] yy);
		logic [5:0]      d1;
		nmtd_pkg::date_t r;
		d1      = dd + 6'd1;
		r.day   = d1[4:0];
		r.month = mo[3:0];
		r.year  = yy;
		if (mo >= 7'd1 && mo <= MonDec && d1 > 6'(month_len(mo, yy))) begin
			r.day = 5'd1;
			if (mo == MonDec) begin
				r.month = 4'd1;
				r.year  = (yy == 7'd99) ? 7'd0 : yy + 7'd1;
			end else begin
				r.month = 4'(mo + 7'd1);
			end
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;

	logic [31:0] diff_s1;
	logic [24:0] tc_s1;
	logic [18:0] dc_s1;
	logic [18:0] hms_s1;
	logic [12:0] ddmm_s1;

	logic [31:0] el_s2;
	logic [6:0]  cc_s2;
	logic [18:0] hms_s2;
	logic [11:0] hhmm_s2;
	logic [12:0] ddmm_s2;
	logic [5:0]  dd_s2;
	logic [6:0]  yy_s2;

	logic [31:0] el_s3;
	logic [22:0] eq_s3;
	logic [6:0]  cc_s3;
	logic [6:0]  ss_s3;
	logic [11:0] hhmm_s3;
	logic [5:0]  hh_s3;
	logic [5:0]  dd_s3;
	logic [6:0]  mo_s3;
	logic [6:0]  yy_s3;

	nmtd_pkg::dec_t dec_s4;

	logic [9:0] er;

	always_comb begin
		er = 10'(el_s3 - 32'(eq_s3) * 32'd1000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= fix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: tick difference, first /100 of both codes
			diff_s1 <= fix.now_tick - fix.log_tick;
			tc_s1   <= fix.time_code;
			dc_s1   <= fix.date_code;
			hms_s1  <= 19'(nmtd_pkg::div100(32'(fix.time_code)));
			ddmm_s1 <= 13'(nmtd_pkg::div100(32'(fix.date_code)));

			// stage 2: scale to ms, hundredths and year digits, second /100
			el_s2   <= diff_s1 * 32'(TICK_MS);
			cc_s2   <= 7'(tc_s1 - 25'(hms_s1) * 25'd100);
			hms_s2  <= hms_s1;
			hhmm_s2 <= 12'(nmtd_pkg::div100(32'(hms_s1)));
			ddmm_s2 <= ddmm_s1;
			dd_s2   <= 6'(nmtd_pkg::div100(32'(ddmm_s1)));
			yy_s2   <= 7'(dc_s1 - 19'(ddmm_s1) * 19'd100);

			// stage 3: whole seconds of elapsed time, more digit splits
			el_s3   <= el_s2;
			eq_s3   <= 23'(nmtd_pkg::div1000(el_s2));
			cc_s3   <= cc_s2;
			ss_s3   <= 7'(hms_s2 - 19'(hhmm_s2) * 19'd100);
			hhmm_s3 <= hhmm_s2;
			hh_s3   <= 6'(nmtd_pkg::div100(32'(hhmm_s2)));
			dd_s3   <= dd_s2;
			mo_s3   <= 7'(ddmm_s2 - 13'(dd_s2) * 13'd100);
			yy_s3   <= yy_s2;

			// stage 4: ms sum below 1990, minute digits, both date choices
			dec_s4.ms              <= 11'(11'(cc_s3) * 11'd10 + 11'(er));
			dec_s4.eq              <= eq_s3;
			dec_s4.ss              <= ss_s3;
			dec_s4.mm              <= 7'(hhmm_s3 - 12'(hh_s3) * 12'd100);
			dec_s4.hh              <= hh_s3;
			dec_s4.date_keep.day   <= dd_s3[4:0];
			dec_s4.date_keep.month <= mo_s3[3:0];
			dec_s4.date_keep.year  <= yy_s3;
			dec_s4.date_next       <= next_date(dd_s3, mo_s3, yy_s3);
		end
	end

	assign dec_valid = v_s4;
	assign dec       = dec_s4;

	`NMTD_ASSERT_IMP(a_dec_digits, v_s4, dec_s4.ms < 11'd1990 && dec_s4.ss < 7'd100 && dec_s4.mm < 7'd100 && dec_s4.hh < 6'd34, "decoded digits out of range")

endmodule
`default_nettype wire

// ===== hdl/nmtd_carry.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmtd_carry
// stages 5-11: millisecond, second, minute and hour carries, hour wrap and
// date selection
// ----------------------------------------------------------------------------
`include "nmea_time_date_rollover_unit_defines.svh"

module nmtd_carry (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            dec_valid,
	input  nmtd_pkg::dec_t  dec,
	output logic            res_valid,
	output nmtd_pkg::utc_t  res
);

	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	logic [9:0]  millis_s5, millis_s6, millis_s7, millis_s8, millis_s9, millis_s10;
	logic [22:0] secsum_s5, secsum_s6;
	logic [6:0]  mm_s5, mm_s6;
	logic [5:0]  hh_s5, hh_s6, hh_s7, hh_s8;
	logic [16:0] sq_s6;
	logic [5:0]  second_s7, second_s8, second_s9, second_s10;
	logic [16:0] minsum_s7, minsum_s8;
	logic [10:0] mq_s8;
	logic [5:0]  minute_s9, minute_s10;
	logic [10:0] hoursum_s9, hoursum_s10;
	logic [5:0]  hq_s10;

	nmtd_pkg::date_t keep_s5, keep_s6, keep_s7, keep_s8, keep_s9, keep_s10;
	nmtd_pkg::date_t next_s5, next_s6, next_s7, next_s8, next_s9, next_s10;

	nmtd_pkg::utc_t out_s11;

	logic ms_carry;

	always_comb begin
		ms_carry = dec.ms >= 11'd1000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s5  <= dec_valid;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 5: ms carry into seconds
			millis_s5 <= 10'(ms_carry ? dec.ms - 11'd1000 : dec.ms);
			secsum_s5 <= dec.eq + 23'(dec.ss) + 23'(ms_carry);
			mm_s5     <= dec.mm;
			hh_s5     <= dec.hh;
			keep_s5   <= dec.date_keep;
			next_s5   <= dec.date_next;

			// stage 6: whole minutes in the second sum
			millis_s6 <= millis_s5;
			secsum_s6 <= secsum_s5;
			sq_s6     <= 17'(nmtd_pkg::div60(32'(secsum_s5)));
			mm_s6     <= mm_s5;
			hh_s6     <= hh_s5;
			keep_s6   <= keep_s5;
			next_s6   <= next_s5;

			// stage 7: second remainder, minute sum
			millis_s7 <= millis_s6;
			second_s7 <= 6'(secsum_s6 - 23'(sq_s6) * 23'd60);
			minsum_s7 <= 17'(mm_s6) + sq_s6;
			hh_s7     <= hh_s6;
			keep_s7   <= keep_s6;
			next_s7   <= next_s6;

			// stage 8: whole hours in the minute sum
			millis_s8 <= millis_s7;
			second_s8 <= second_s7;
			minsum_s8 <= minsum_s7;
			mq_s8     <= 11'(nmtd_pkg::div60(32'(minsum_s7)));
			hh_s8     <= hh_s7;
			keep_s8   <= keep_s7;
			next_s8   <= next_s7;

			// stage 9: minute remainder, hour sum
			millis_s9  <= millis_s8;
			second_s9  <= second_s8;
			minute_s9  <= 6'(minsum_s8 - 17'(mq_s8) * 17'd60);
			hoursum_s9 <= 11'(hh_s8) + mq_s8;
			keep_s9    <= keep_s8;
			next_s9    <= next_s8;

			// stage 10: day count in the hour sum
			millis_s10  <= millis_s9;
			second_s10  <= second_s9;
			minute_s10  <= minute_s9;
			hoursum_s10 <= hoursum_s9;
			hq_s10      <= 6'(nmtd_pkg::div24(32'(hoursum_s9)));
			keep_s10    <= keep_s9;
			next_s10    <= next_s9;

			// stage 11: hour wrap, at most one day forward
			out_s11.hour         <= 5'(hoursum_s10 - 11'(hq_s10) * 11'd24);
			out_s11.minute       <= minute_s10;
			out_s11.second       <= second_s10;
			out_s11.millis       <= millis_s10;
			out_s11.day          <= (hq_s10 != 6'd0) ? next_s10.day : keep_s10.day;
			out_s11.month        <= (hq_s10 != 6'd0) ? next_s10.month : keep_s10.month;
			out_s11.year         <= (hq_s10 != 6'd0) ? next_s10.year : keep_s10.year;
			out_s11.day_advanced <= hq_s10 != 6'd0;
		end
	end

	assign res_valid = v_s11;
	assign res       = out_s11;

	`NMTD_ASSERT_IMP(a_carry_wrap, v_s10, (hq_s10 != 6'd0) == (hoursum_s10 >= 11'd24), "hour wrap disagrees with hour sum")
	`NMTD_ASSERT_IMP(a_carry_range, v_s11, out_s11.hour < 5'd24 && out_s11.minute < 6'd60 && out_s11.second < 6'd60 && out_s11.millis < 10'd1000, "time field out of range")

endmodule
`default_nettype wire

// ===== hdl/nmtd_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmtd_skid
// output skid register; holds one result while the receiver stalls and
// freezes the pipeline until it drains
// ----------------------------------------------------------------------------
`include "nmea_time_date_rollover_unit_defines.svh"

module nmtd_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pipe_valid,
	input  nmtd_pkg::utc_t  pipe_data,
	output logic            pipe_en,
	output logic            utc_valid,
	input  logic            utc_ready,
	output nmtd_pkg::utc_t  utc
);

	logic           skid_v_q;
	nmtd_pkg::utc_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (utc_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (pipe_valid && !utc_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= pipe_data;
		end
	end

	// pipeline moves only while the skid slot is free
	assign pipe_en   = !skid_v_q;
	assign utc_valid = skid_v_q || pipe_valid;
	assign utc       = skid_v_q ? skid_q : pipe_data;

	`NMTD_ASSERT_NEXT(a_skid_fill, !skid_v_q && pipe_valid && !utc_ready, skid_v_q && skid_q == $past(pipe_data), "stalled result not caught")
	`NMTD_ASSERT_NEXT(a_skid_hold, skid_v_q && !utc_ready, skid_v_q && $stable(skid_q), "held result lost")

endmodule
`default_nettype wire

// ===== hdl/nmea_time_date_rollover_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_time_date_rollover_unit
// ----------------------------------------------------------------------------
// Decodes an NMEA hhmmsscc time and ddmmyy date and moves them forward by the
// time elapsed between log_tick and now_tick ((now - log) * TICK_MS ms, mod
// 2^32). The hour wraps mod 24 and a wrap moves the date one day forward.
//
// fix channel (fix_valid/fix_ready/fix) takes one request per transaction;
// utc channel (utc_valid/utc_ready/utc) returns exactly one result each, in
// order.
// The result passes through eleven register stages (four decode stages,
// seven carry stages) before utc_valid rises; a stall freezes them.
// Throughput: one transaction per cycle while utc_ready is high.
// A stalled result moves into a skid register; the pipeline then freezes
// and fix_ready drops until that result is taken, so nothing is dropped or
// repeated.
// Reset clears all valid bits and the skid slot; no results are pending
// afterwards and fix_ready is high.
// ----------------------------------------------------------------------------
module nmea_time_date_rollover_unit #(
	parameter int unsigned TICK_MS = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fix_valid,
	output logic            fix_ready,
	input  nmtd_pkg::fix_t  fix,
	output logic            utc_valid,
	input  logic            utc_ready,
	output nmtd_pkg::utc_t  utc
);

	logic           pipe_en;
	logic           dec_valid;
	nmtd_pkg::dec_t dec;
	logic           res_valid;
	nmtd_pkg::utc_t res;

	assign fix_ready = pipe_en;

	nmtd_decode #(
		.TICK_MS(TICK_MS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.fix_valid (fix_valid),
		.fix       (fix),
		.dec_valid (dec_valid),
		.dec       (dec)
	);

	nmtd_carry u_carry (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.dec_valid (dec_valid),
		.dec       (dec),
		.res_valid (res_valid),
		.res       (res)
	);

	nmtd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (res_valid),
		.pipe_data  (res),
		.pipe_en    (pipe_en),
		.utc_valid  (utc_valid),
		.utc_ready  (utc_ready),
		.utc        (utc)
	);

endmodule
`default_nettype wire
